/* design/lss_pkg.sv */
// lss_pkg: shared types, constants and helpers for limited_setpoint_store.
// Used by every module of the block and by the port checker.
// No dependencies.
package lss_pkg;

   localparam int unsigned SETTING_WIDTH_DEFAULT = 16;
   localparam int unsigned FIELD_WIDTH           = 16;
   localparam int unsigned NUM_ENTRIES           = 6;
   localparam int unsigned NUM_REGS              = 8;
   localparam int unsigned CSR_ADDR_WIDTH        = 5;
   localparam int unsigned CSR_DATA_WIDTH        = 32;

   typedef logic [2:0] reg_idx_type;
   typedef logic [2:0] entry_idx_type;

   // configuration register map (byte address = 4 * index)
   localparam reg_idx_type REG_VOLT5_ABS_MIN      = 3'd0;
   localparam reg_idx_type REG_VOLT5_ABS_MAX      = 3'd1;
   localparam reg_idx_type REG_VOLT12_ABS_MIN     = 3'd2;
   localparam reg_idx_type REG_VOLT12_ABS_MAX     = 3'd3;
   localparam reg_idx_type REG_LOWRANGE_ABS_MIN   = 3'd4;
   localparam reg_idx_type REG_LOWRANGE_ABS_MAX   = 3'd5;
   localparam reg_idx_type REG_HIGHRANGE_ABS_MIN  = 3'd6;
   localparam reg_idx_type REG_HIGHRANGE_ABS_MAX  = 3'd7;

   // entry order
   localparam entry_idx_type ENTRY_V5_VOLT      = 3'd0;
   localparam entry_idx_type ENTRY_V5_CUR_LOW   = 3'd1;
   localparam entry_idx_type ENTRY_V5_CUR_HIGH  = 3'd2;
   localparam entry_idx_type ENTRY_V12_VOLT     = 3'd3;
   localparam entry_idx_type ENTRY_V12_CUR_LOW  = 3'd4;
   localparam entry_idx_type ENTRY_V12_CUR_HIGH = 3'd5;

   localparam logic [FIELD_WIDTH-1:0] RESET_SETTING [NUM_ENTRIES] = '{
      16'd5000, 16'd4000, 16'd4000, 16'd12000, 16'd2000, 16'd4000
   };

   // absolute-min register per entry; the max register is the odd one above it
   localparam reg_idx_type ABS_MIN_REG [NUM_ENTRIES] = '{
      REG_VOLT5_ABS_MIN, REG_LOWRANGE_ABS_MIN, REG_HIGHRANGE_ABS_MIN,
      REG_VOLT12_ABS_MIN, REG_LOWRANGE_ABS_MIN, REG_LOWRANGE_ABS_MIN
   };

   localparam logic CMD_SET_VALUE = 1'b0;
   localparam logic CMD_SET_LIMIT = 1'b1;
   localparam logic SIDE_LOW      = 1'b0;
   localparam logic SIDE_HIGH     = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_SOFT_MIN = 3'd1,
      STATUS_SOFT_MAX = 3'd2,
      STATUS_ABS_MIN  = 3'd3,
      STATUS_ABS_MAX  = 3'd4
   } status_type;

   typedef struct packed {
      logic               command;
      logic               channel_sel;
      logic               quantity;
      logic               range_sel;
      logic               limit_side;
      logic               limit_enable;
      logic signed [31:0] target_value;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [FIELD_WIDTH-1:0] setting_out;
      logic [FIELD_WIDTH-1:0] low_limit_out;
      logic [FIELD_WIDTH-1:0] high_limit_out;
      logic                   low_enabled_out;
      logic                   high_enabled_out;
   } rsp_type;

   function automatic entry_idx_type entry_index(input logic ch, input logic qty,
                                                 input logic rng);
      entry_idx_type idx;
      if (!qty) begin
         idx = ch ? ENTRY_V12_VOLT : ENTRY_V5_VOLT;
      end else if (!rng) begin
         idx = ch ? ENTRY_V12_CUR_LOW : ENTRY_V5_CUR_LOW;
      end else begin
         idx = ch ? ENTRY_V12_CUR_HIGH : ENTRY_V5_CUR_HIGH;
      end
      return idx;
   endfunction

   function automatic reg_idx_type abs_max_reg(input reg_idx_type min_reg);
      return {min_reg[2:1], 1'b1};
   endfunction

endpackage

/* design/lss_csr.sv */
// lss_csr: APB-style register file for the eight absolute limits.
// Depends on lss_pkg.
module lss_csr import lss_pkg::*; #(
   parameter int unsigned SW = FIELD_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output logic [SW-1:0]             cfg_regs [NUM_REGS]
);

   logic [SW-1:0] cfg_ff [NUM_REGS];
   reg_idx_type   idx;
   logic          wr_en;

   assign idx   = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            // odd registers are maxima and reset to all ones
            cfg_ff[i] <= (i % 2 == 1) ? '1 : '0;
         end
      end else if (wr_en) begin
         cfg_ff[idx] <= csr_pwdata[SW-1:0];
      end
   end

   assign csr_prdata = CSR_DATA_WIDTH'(cfg_ff[idx]);
   assign csr_pready = 1'b1;
   assign cfg_regs   = cfg_ff;

endmodule

/* design/lss_entry_table.sv */
// lss_entry_table: six setpoint entries (setting, soft limits, enables).
// One read/write port at the addressed entry. Depends on lss_pkg.
module lss_entry_table import lss_pkg::*; #(
   parameter int unsigned SW = FIELD_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   input  entry_idx_type idx,
   input  logic          wr_en,
   input  logic [SW-1:0] wr_setting,
   input  logic [SW-1:0] wr_low,
   input  logic [SW-1:0] wr_high,
   input  logic          wr_low_en,
   input  logic          wr_high_en,
   output logic [SW-1:0] rd_setting,
   output logic [SW-1:0] rd_low,
   output logic [SW-1:0] rd_high,
   output logic          rd_low_en,
   output logic          rd_high_en
);

   logic [SW-1:0] setting_ff [NUM_ENTRIES];
   logic [SW-1:0] low_ff     [NUM_ENTRIES];
   logic [SW-1:0] high_ff    [NUM_ENTRIES];
   logic          low_en_ff  [NUM_ENTRIES];
   logic          high_en_ff [NUM_ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            setting_ff[i] <= RESET_SETTING[i][SW-1:0];
            low_ff[i]     <= '0;
            high_ff[i]    <= '1;
            low_en_ff[i]  <= 1'b0;
            high_en_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         setting_ff[idx] <= wr_setting;
         low_ff[idx]     <= wr_low;
         high_ff[idx]    <= wr_high;
         low_en_ff[idx]  <= wr_low_en;
         high_en_ff[idx] <= wr_high_en;
      end
   end

   assign rd_setting = setting_ff[idx];
   assign rd_low     = low_ff[idx];
   assign rd_high    = high_ff[idx];
   assign rd_low_en  = low_en_ff[idx];
   assign rd_high_en = high_en_ff[idx];

endmodule

/* design/lss_update.sv */
// lss_update: clamp logic for one item; new entry contents and status.
// Purely combinational. Depends on lss_pkg.
module lss_update import lss_pkg::*; #(
   parameter int unsigned SW = FIELD_WIDTH
) (
   input  req_type       req,
   input  logic [SW-1:0] cur_setting,
   input  logic [SW-1:0] cur_low,
   input  logic [SW-1:0] cur_high,
   input  logic          cur_low_en,
   input  logic          cur_high_en,
   input  logic [SW-1:0] abs_min,
   input  logic [SW-1:0] abs_max,
   output logic [SW-1:0] new_setting,
   output logic [SW-1:0] new_low,
   output logic [SW-1:0] new_high,
   output logic          new_low_en,
   output logic          new_high_en,
   output status_type    status
);

   function automatic logic signed [31:0] ext(input logic [SW-1:0] x);
      return $signed(32'(x));
   endfunction

   logic signed [31:0] v_abs;
   logic signed [31:0] v_set;
   status_type         st_abs;
   status_type         st_set;

   always_comb begin
      // new limit: absolute clamp only
      v_abs  = $signed(req.target_value);
      st_abs = STATUS_OK;
      if (v_abs <= ext(abs_min)) begin
         v_abs  = ext(abs_min);
         st_abs = STATUS_ABS_MIN;
      end
      if (v_abs >= ext(abs_max)) begin
         v_abs  = ext(abs_max);
         st_abs = STATUS_ABS_MAX;
      end

      new_low     = cur_low;
      new_high    = cur_high;
      new_low_en  = cur_low_en;
      new_high_en = cur_high_en;
      if (req.command == CMD_SET_LIMIT) begin
         if (req.limit_side == SIDE_LOW) begin
            new_low    = v_abs[SW-1:0];
            new_low_en = req.limit_enable;
         end else begin
            new_high    = v_abs[SW-1:0];
            new_high_en = req.limit_enable;
         end
      end

      // setting: soft low, soft high, abs min, abs max; last hit wins
      v_set  = (req.command == CMD_SET_LIMIT) ? ext(cur_setting) : $signed(req.target_value);
      st_set = STATUS_OK;
      if (new_low_en && v_set <= ext(new_low)) begin
         v_set  = ext(new_low);
         st_set = STATUS_SOFT_MIN;
      end
      if (new_high_en && v_set >= ext(new_high)) begin
         v_set  = ext(new_high);
         st_set = STATUS_SOFT_MAX;
      end
      if (v_set <= ext(abs_min)) begin
         v_set  = ext(abs_min);
         st_set = STATUS_ABS_MIN;
      end
      if (v_set >= ext(abs_max)) begin
         v_set  = ext(abs_max);
         st_set = STATUS_ABS_MAX;
      end

      new_setting = v_set[SW-1:0];
      status      = (req.command == CMD_SET_LIMIT) ? st_abs : st_set;
   end

endmodule

/* design/limited_setpoint_store.sv */
// limited_setpoint_store: six power-supply setpoint entries with soft and
// absolute limits. Depends on lss_pkg, lss_csr, lss_entry_table, lss_update.
//
//   Channel  Direction  Handshake              Beat payload
//   req_     in         req_valid / req_stall  req_type: command, entry select, value
//   rsp_     out        rsp_valid / rsp_stall  rsp_type: status, entry contents
//   csr_     in/out     APB psel/penable       eight 16-bit limit registers
//
// One beat per cycle sustained while rsp_stall is low; path: input register,
// then the clamp logic and entry table update into the result register.
// The entry table is written when an item moves into the result register,
// so the next item already sees the updated entry.
// Reset (synchronous) clears both valid flags and loads the table and limit
// registers with their defaults; no clearing pass.
// A stalled result holds the item in the input register; req_stall rises only
// when both registers are full.
module limited_setpoint_store import lss_pkg::*; #(
   parameter int unsigned SETTING_WIDTH = SETTING_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // item channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   // configuration port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   // stored width: at most the 16-bit field width is ever used
   localparam int unsigned SW = (SETTING_WIDTH < FIELD_WIDTH) ? SETTING_WIDTH : FIELD_WIDTH;

   logic          in_valid_ff, in_valid_in;
   req_type       in_data_ff;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_data_ff;
   logic          req_accept;
   logic          advance;

   logic [SW-1:0] cfg_regs [NUM_REGS];
   entry_idx_type entry;
   reg_idx_type   min_reg;
   logic [SW-1:0] abs_min, abs_max;

   logic [SW-1:0] cur_setting, cur_low, cur_high;
   logic          cur_low_en, cur_high_en;
   logic [SW-1:0] new_setting, new_low, new_high;
   logic          new_low_en, new_high_en;
   status_type    status;

   // ---- flow control ----
   assign advance      = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall    = in_valid_ff & ~advance;
   assign req_accept   = req_valid & ~req_stall;
   assign in_valid_in  = req_accept | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff.status           <= status;
         out_data_ff.setting_out      <= FIELD_WIDTH'(new_setting);
         out_data_ff.low_limit_out    <= FIELD_WIDTH'(new_low);
         out_data_ff.high_limit_out   <= FIELD_WIDTH'(new_high);
         out_data_ff.low_enabled_out  <= new_low_en;
         out_data_ff.high_enabled_out <= new_high_en;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // ---- entry addressing and absolute range lookup ----
   assign entry   = entry_index(in_data_ff.channel_sel, in_data_ff.quantity,
                                in_data_ff.range_sel);
   assign min_reg = ABS_MIN_REG[entry];
   assign abs_min = cfg_regs[min_reg];
   assign abs_max = cfg_regs[abs_max_reg(min_reg)];

   lss_csr #(.SW(SW)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg_regs    (cfg_regs)
   );

   lss_entry_table #(.SW(SW)) u_table (
      .clock      (clock),
      .reset      (reset),
      .idx        (entry),
      .wr_en      (advance),
      .wr_setting (new_setting),
      .wr_low     (new_low),
      .wr_high    (new_high),
      .wr_low_en  (new_low_en),
      .wr_high_en (new_high_en),
      .rd_setting (cur_setting),
      .rd_low     (cur_low),
      .rd_high    (cur_high),
      .rd_low_en  (cur_low_en),
      .rd_high_en (cur_high_en)
   );

   lss_update #(.SW(SW)) u_update (
      .req         (in_data_ff),
      .cur_setting (cur_setting),
      .cur_low     (cur_low),
      .cur_high    (cur_high),
      .cur_low_en  (cur_low_en),
      .cur_high_en (cur_high_en),
      .abs_min     (abs_min),
      .abs_max     (abs_max),
      .new_setting (new_setting),
      .new_low     (new_low),
      .new_high    (new_high),
      .new_low_en  (new_low_en),
      .new_high_en (new_high_en),
      .status      (status)
   );

endmodule

/* design/lss_checker.sv */
// lss_checker: port-level assertions for limited_setpoint_store, with bind.
// Depends on lss_pkg and the top level.
module lss_checker import lss_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // an accepted item must be followed by rsp_valid
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("accepted item produced no result");

   // soft clamp status means the setting sits on that enabled limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_SOFT_MIN |->
         rsp_data.low_enabled_out && rsp_data.setting_out == rsp_data.low_limit_out)
      else $error("soft min status without matching low limit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_SOFT_MAX |->
         rsp_data.high_enabled_out && rsp_data.setting_out == rsp_data.high_limit_out)
      else $error("soft max status without matching high limit");

   // no result right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind limited_setpoint_store lss_checker u_lss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/sv/limited_setpoint_store_checker.sv */
`timescale 1ns / 100ps
// Checker for limited_setpoint_store: follows limit-register traffic, predicts
// one entry report per accepted request beat and compares every result beat.
// Depends on lss_pkg.
module limited_setpoint_store_checker import lss_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rsp_type                   rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   input  logic                      csr_pready,
   output int unsigned               fail_count,
   output int unsigned               pending_count,
   output int unsigned               report_count
);

   localparam int unsigned REPORT_LIMIT = 40;

   // absolute bound registers of each entry
   localparam reg_idx_type MIN_REG_OF [NUM_ENTRIES] = '{
      REG_VOLT5_ABS_MIN, REG_LOWRANGE_ABS_MIN, REG_HIGHRANGE_ABS_MIN,
      REG_VOLT12_ABS_MIN, REG_LOWRANGE_ABS_MIN, REG_LOWRANGE_ABS_MIN
   };
   localparam reg_idx_type MAX_REG_OF [NUM_ENTRIES] = '{
      REG_VOLT5_ABS_MAX, REG_LOWRANGE_ABS_MAX, REG_HIGHRANGE_ABS_MAX,
      REG_VOLT12_ABS_MAX, REG_LOWRANGE_ABS_MAX, REG_LOWRANGE_ABS_MAX
   };
   localparam logic [FIELD_WIDTH-1:0] POWER_ON_SETTING [NUM_ENTRIES] = '{
      16'd5000, 16'd4000, 16'd4000, 16'd12000, 16'd2000, 16'd4000
   };

   logic [FIELD_WIDTH-1:0] abs_bound [NUM_REGS];
   logic [FIELD_WIDTH-1:0] setpoint [NUM_ENTRIES];
   logic [FIELD_WIDTH-1:0] soft_low [NUM_ENTRIES];
   logic [FIELD_WIDTH-1:0] soft_high [NUM_ENTRIES];
   logic                   soft_low_on [NUM_ENTRIES];
   logic                   soft_high_on [NUM_ENTRIES];
   rsp_type                entry_report_q [$];
   int unsigned            errors;
   int unsigned            checked;

   function automatic entry_idx_type addressed_entry(input req_type r);
      if (!r.quantity) return r.channel_sel ? ENTRY_V12_VOLT : ENTRY_V5_VOLT;
      if (!r.range_sel) return r.channel_sel ? ENTRY_V12_CUR_LOW : ENTRY_V5_CUR_LOW;
      return r.channel_sel ? ENTRY_V12_CUR_HIGH : ENTRY_V5_CUR_HIGH;
   endfunction

   // min first, then max; both hold at equality, so max wins on a crossed range
   function automatic status_type clamp_absolute(input entry_idx_type e, input longint v_in,
                                                 output longint v_out);
      longint     lo;
      longint     hi;
      status_type st;
      lo    = longint'(abs_bound[MIN_REG_OF[e]]);
      hi    = longint'(abs_bound[MAX_REG_OF[e]]);
      v_out = v_in;
      st    = STATUS_OK;
      if (v_out <= lo) begin
         v_out = lo;
         st    = STATUS_ABS_MIN;
      end
      if (v_out >= hi) begin
         v_out = hi;
         st    = STATUS_ABS_MAX;
      end
      return st;
   endfunction

   function automatic status_type apply_setpoint(input entry_idx_type e, input longint req_val);
      longint     v;
      longint     clamped;
      status_type st;
      status_type abs_st;
      v  = req_val;
      st = STATUS_OK;
      if (soft_low_on[e] && v <= longint'(soft_low[e])) begin
         v  = longint'(soft_low[e]);
         st = STATUS_SOFT_MIN;
      end
      if (soft_high_on[e] && v >= longint'(soft_high[e])) begin
         v  = longint'(soft_high[e]);
         st = STATUS_SOFT_MAX;
      end
      abs_st = clamp_absolute(e, v, clamped);
      if (abs_st != STATUS_OK) st = abs_st;
      setpoint[e] = clamped[FIELD_WIDTH-1:0];
      return st;
   endfunction

   function automatic rsp_type predict_report(input req_type r);
      entry_idx_type e;
      longint        v;
      longint        lim;
      status_type    st;
      rsp_type       rep;
      e = addressed_entry(r);
      v = longint'($signed(r.target_value));
      if (r.command == CMD_SET_VALUE) begin
         st = apply_setpoint(e, v);
      end else begin
         st = clamp_absolute(e, v, lim);
         if (r.limit_side == SIDE_LOW) begin
            soft_low[e]    = lim[FIELD_WIDTH-1:0];
            soft_low_on[e] = r.limit_enable;
         end else begin
            soft_high[e]    = lim[FIELD_WIDTH-1:0];
            soft_high_on[e] = r.limit_enable;
         end
         // setting is pulled back inside the new limits; its status is dropped
         void'(apply_setpoint(e, longint'(setpoint[e])));
      end
      rep.status           = st;
      rep.setting_out      = setpoint[e];
      rep.low_limit_out    = soft_low[e];
      rep.high_limit_out   = soft_high[e];
      rep.low_enabled_out  = soft_low_on[e];
      rep.high_enabled_out = soft_high_on[e];
      return rep;
   endfunction

   task automatic compare_field(input string name, input logic [FIELD_WIDTH-1:0] want,
                                input logic [FIELD_WIDTH-1:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type     want;
      reg_idx_type ridx;
      if (reset) begin
         for (int e = 0; e < NUM_ENTRIES; e++) begin
            abs_bound[MIN_REG_OF[e]] = '0;
            abs_bound[MAX_REG_OF[e]] = '1;
            setpoint[e]     = POWER_ON_SETTING[e];
            soft_low[e]     = '0;
            soft_high[e]    = '1;
            soft_low_on[e]  = 1'b0;
            soft_high_on[e] = 1'b0;
         end
         entry_report_q.delete();
         errors  = 0;
         checked = 0;
      end else begin
         ridx = reg_idx_type'(csr_paddr >> 2);
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               abs_bound[ridx] = csr_pwdata[FIELD_WIDTH-1:0];
            end else if (csr_prdata !==
                         {{(CSR_DATA_WIDTH-FIELD_WIDTH){1'b0}}, abs_bound[ridx]}) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: register %0d read mismatch, expected %0d, actual %0d",
                           $time, ridx, abs_bound[ridx], csr_prdata);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (entry_report_q.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: result beat with nothing outstanding, expected none, actual %h",
                           $time, rsp_data);
            end else begin
               want = entry_report_q.pop_front();
               compare_field("status", FIELD_WIDTH'(want.status),
                             FIELD_WIDTH'(rsp_data.status));
               compare_field("setting", want.setting_out, rsp_data.setting_out);
               compare_field("low limit", want.low_limit_out, rsp_data.low_limit_out);
               compare_field("high limit", want.high_limit_out, rsp_data.high_limit_out);
               compare_field("low enable", FIELD_WIDTH'(want.low_enabled_out),
                             FIELD_WIDTH'(rsp_data.low_enabled_out));
               compare_field("high enable", FIELD_WIDTH'(want.high_enabled_out),
                             FIELD_WIDTH'(rsp_data.high_enabled_out));
            end
         end
         if (req_valid && !req_stall) entry_report_q.push_back(predict_report(req_data));
      end
      fail_count    <= errors;
      pending_count <= entry_report_q.size();
      report_count  <= checked;
   end

endmodule

/* tb/sv/limited_setpoint_store_tb.sv */
`timescale 1ns / 100ps
// Testbench top for limited_setpoint_store: drives request beats, limit-register
// traffic and result-side stalls, then gives the verdict.
// Depends on lss_pkg, limited_setpoint_store and limited_setpoint_store_checker.
module limited_setpoint_store_tb;
   import lss_pkg::*;

   localparam int unsigned CLOCK_HALF      = 6;     // ns, 12 ns period
   localparam int unsigned RESET_CYCLES    = 4;
   localparam int unsigned WATCHDOG_LIMIT  = 1000;  // cycles with no beat at all
   localparam int unsigned SETTLE_CYCLES   = 10;
   localparam int unsigned ITEMS_PER_PHASE = 135;
   localparam int unsigned DRAIN_EVERY     = 45;    // sender holds off until drained
   localparam int unsigned HINTS           = 8;

   // entry select encodings of the request fields
   localparam logic CH_5V       = 1'b0;
   localparam logic CH_12V      = 1'b1;
   localparam logic QTY_VOLT    = 1'b0;
   localparam logic QTY_CURRENT = 1'b1;
   localparam logic RANGE_LOW   = 1'b0;
   localparam logic RANGE_HIGH  = 1'b1;
   localparam logic LIMIT_OFF   = 1'b0;
   localparam logic LIMIT_ON    = 1'b1;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   req_type                   req_data    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned report_count;

   int unsigned send_idle_pct;   // chance per cycle that the sender idles
   int unsigned rsp_stall_pct;   // chance per cycle that the receiver stalls
   int unsigned items_sent       = 0;
   int unsigned settings_applied = 0;
   int unsigned quiet_cycles     = 0;

   // limit values last programmed, and recent soft-limit requests; both steer
   // random values toward the clamp boundaries so equality hits are common
   logic [FIELD_WIDTH-1:0] cfg_plan [NUM_REGS];
   logic signed [31:0]     soft_hint [HINTS];
   int unsigned            hint_slot = 0;

   always #(CLOCK_HALF) clock = ~clock;

   limited_setpoint_store i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   limited_setpoint_store_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .report_count  (report_count)
   );

   // Receiver: a fresh stall decision every cycle, whether or not a beat waits.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Watchdog: any beat on either channel or any register access restarts it.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_req(input logic cmd, input logic ch, input logic qty,
                                        input logic rng, input logic side, input logic en,
                                        input logic signed [31:0] value);
      req_type r;
      r.command      = cmd;
      r.channel_sel  = ch;
      r.quantity     = qty;
      r.range_sel    = rng;
      r.limit_side   = side;
      r.limit_enable = en;
      r.target_value = value;
      return r;
   endfunction

   // Mix of full-range noise, plain 16-bit values, values right around the
   // programmed absolute bounds and around recent soft limits, and the extremes.
   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0, 1:    v = $urandom;
         2, 3, 4: v = $urandom_range(0, 65535);
         5, 6:    v = cfg_plan[$urandom_range(0, NUM_REGS - 1)] + $urandom_range(0, 4) - 2;
         7, 8:    v = soft_hint[$urandom_range(0, HINTS - 1)] + $urandom_range(0, 4) - 2;
         default: begin
            case ($urandom_range(0, 3))
               0:       v = 32'sh8000_0000;
               1:       v = 32'sh7FFF_FFFF;
               2:       v = -32'sd1;
               default: v = 32'sd65536;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic req_type random_item();
      req_type r;
      r.command      = ($urandom_range(0, 99) < 40) ? CMD_SET_LIMIT : CMD_SET_VALUE;
      r.channel_sel  = 1'($urandom_range(0, 1));
      r.quantity     = 1'($urandom_range(0, 1));
      r.range_sel    = 1'($urandom_range(0, 1));
      r.limit_side   = 1'($urandom_range(0, 1));
      r.limit_enable = ($urandom_range(0, 99) < 70);
      r.target_value = pick_value();
      return r;
   endfunction

   // Holds the beat until it is taken; valid stays up into the next beat
   // unless the sender decides to idle.
   task automatic send_item(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Sender pauses until every outstanding entry report has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // One APB transfer: setup, then access until pready. psel is left high so
   // transfers can run back to back; the caller closes the burst.
   task automatic csr_access(input logic write, input reg_idx_type idx,
                             input logic [FIELD_WIDTH-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_WIDTH'({idx, 2'b00});
      // junk in the upper half checks that only the low 16 bits are kept
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   // Writes every limit register from cfg_plan and reads each one back.
   task automatic program_limits();
      for (int i = 0; i < NUM_REGS; i++) csr_access(1'b1, reg_idx_type'(i), cfg_plan[i]);
      for (int i = 0; i < NUM_REGS; i++) csr_access(1'b0, reg_idx_type'(i), '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   // Mostly ordinary ranges, with some collapsed and some crossed (min above max).
   task automatic plan_random_limits();
      int unsigned mode;
      for (int p = 0; p < NUM_REGS; p += 2) begin
         mode = $urandom_range(0, 99);
         if (mode < 70) begin
            cfg_plan[p]     = 16'($urandom_range(0, 30000));
            cfg_plan[p + 1] = 16'($urandom_range(cfg_plan[p], 65535));
         end else if (mode < 85) begin
            cfg_plan[p]     = 16'($urandom_range(0, 65535));
            cfg_plan[p + 1] = cfg_plan[p];
         end else begin
            cfg_plan[p + 1] = 16'($urandom_range(0, 30000));
            cfg_plan[p]     = 16'($urandom_range(cfg_plan[p + 1] + 1, 65535));
         end
      end
   endtask

   task automatic run_random(input int unsigned count);
      req_type item;
      for (int unsigned k = 0; k < count; k++) begin
         item = random_item();
         if (item.command == CMD_SET_LIMIT) begin
            soft_hint[hint_slot] = item.target_value;
            hint_slot = (hint_slot + 1) % HINTS;
         end
         send_item(item);
         if (k % DRAIN_EVERY == DRAIN_EVERY - 1) drain();
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < NUM_REGS; i += 2) begin
         cfg_plan[i]     = '0;
         cfg_plan[i + 1] = '1;
      end
      for (int i = 0; i < HINTS; i++) soft_hint[i] = $urandom_range(0, 65535);
      send_idle_pct = 19;
      rsp_stall_pct = 79;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, power-on limits (full 16-bit range) ---
      send_item(make_req(CMD_SET_VALUE, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_LOW, LIMIT_OFF,
                         32'sd3000));
      // negative and zero both hit the absolute minimum
      send_item(make_req(CMD_SET_VALUE, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_LOW, LIMIT_OFF,
                         -32'sd1));
      send_item(make_req(CMD_SET_VALUE, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_LOW, LIMIT_OFF,
                         32'sd0));
      send_item(make_req(CMD_SET_VALUE, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_LOW, LIMIT_OFF,
                         32'sd65535));
      send_item(make_req(CMD_SET_VALUE, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_LOW, LIMIT_OFF,
                         32'sh7FFF_FFFF));
      // limit fields set high on a set-value: must be ignored
      send_item(make_req(CMD_SET_VALUE, CH_5V, QTY_VOLT, RANGE_HIGH, SIDE_HIGH, LIMIT_ON,
                         32'sh8000_0000));
      // soft low, then hits below and exactly at it
      send_item(make_req(CMD_SET_LIMIT, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_LOW, LIMIT_ON,
                         32'sd1000));
      send_item(make_req(CMD_SET_VALUE, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_LOW, LIMIT_OFF,
                         32'sd500));
      send_item(make_req(CMD_SET_VALUE, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_LOW, LIMIT_OFF,
                         32'sd1000));
      // soft high, then a setting above it is clamped to it
      send_item(make_req(CMD_SET_LIMIT, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_HIGH, LIMIT_ON,
                         32'sd2000));
      send_item(make_req(CMD_SET_VALUE, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_LOW, LIMIT_OFF,
                         32'sd2500));
      // soft low above soft high: low clamp then high clamp, high wins
      send_item(make_req(CMD_SET_LIMIT, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_LOW, LIMIT_ON,
                         32'sd3000));
      send_item(make_req(CMD_SET_VALUE, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_LOW, LIMIT_OFF,
                         32'sd2500));
      // set-limit clamped by the absolute range, and a limit disabled
      send_item(make_req(CMD_SET_LIMIT, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_LOW, LIMIT_ON,
                         -32'sd5));
      send_item(make_req(CMD_SET_LIMIT, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_HIGH, LIMIT_OFF,
                         32'sd100000));
      // remaining entries; range_sel on a voltage entry is ignored
      send_item(make_req(CMD_SET_VALUE, CH_12V, QTY_VOLT, RANGE_HIGH, SIDE_LOW, LIMIT_OFF,
                         32'sd7000));
      send_item(make_req(CMD_SET_VALUE, CH_5V, QTY_CURRENT, RANGE_LOW, SIDE_LOW, LIMIT_OFF,
                         32'sd100));
      send_item(make_req(CMD_SET_VALUE, CH_5V, QTY_CURRENT, RANGE_HIGH, SIDE_LOW, LIMIT_OFF,
                         32'sd200));
      send_item(make_req(CMD_SET_VALUE, CH_12V, QTY_CURRENT, RANGE_LOW, SIDE_LOW, LIMIT_OFF,
                         32'sd300));
      send_item(make_req(CMD_SET_VALUE, CH_12V, QTY_CURRENT, RANGE_HIGH, SIDE_LOW, LIMIT_OFF,
                         32'sd400));
      drain();

      // --- directed, odd absolute ranges: crossed, collapsed, pinned to the rails ---
      cfg_plan[REG_VOLT5_ABS_MIN]     = 16'd3000;
      cfg_plan[REG_VOLT5_ABS_MAX]     = 16'd1000;
      cfg_plan[REG_VOLT12_ABS_MIN]    = 16'd5000;
      cfg_plan[REG_VOLT12_ABS_MAX]    = 16'd5000;
      cfg_plan[REG_LOWRANGE_ABS_MIN]  = 16'hFFFF;
      cfg_plan[REG_LOWRANGE_ABS_MAX]  = 16'hFFFF;
      cfg_plan[REG_HIGHRANGE_ABS_MIN] = 16'd0;
      cfg_plan[REG_HIGHRANGE_ABS_MAX] = 16'd0;
      program_limits();
      // crossed range: min clamp hits, then max clamp wins
      send_item(make_req(CMD_SET_VALUE, CH_5V, QTY_VOLT, RANGE_LOW, SIDE_LOW, LIMIT_OFF,
                         32'sd2000));
      send_item(make_req(CMD_SET_VALUE, CH_12V, QTY_VOLT, RANGE_LOW, SIDE_LOW, LIMIT_OFF,
                         32'sd5000));
      send_item(make_req(CMD_SET_LIMIT, CH_5V, QTY_CURRENT, RANGE_HIGH, SIDE_HIGH, LIMIT_ON,
                         32'sd30));
      // 12V high range shares the low-range bounds
      send_item(make_req(CMD_SET_VALUE, CH_12V, QTY_CURRENT, RANGE_HIGH, SIDE_LOW, LIMIT_OFF,
                         32'sd1));
      drain();

      // --- random: sender mostly busy, receiver mostly stalling ---
      plan_random_limits();
      program_limits();
      run_random(ITEMS_PER_PHASE);

      // --- random: roles swapped ---
      send_idle_pct = 79;
      rsp_stall_pct = 19;
      plan_random_limits();
      program_limits();
      run_random(ITEMS_PER_PHASE);

      // --- random: full rate both sides, widest absolute ranges ---
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      for (int i = 0; i < NUM_REGS; i += 2) begin
         cfg_plan[i]     = '0;
         cfg_plan[i + 1] = '1;
      end
      program_limits();
      run_random(ITEMS_PER_PHASE);

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d request beats over all six entries and %0d limit settings;",
               items_sent, settings_applied);
      $display("%0d entry reports compared, %0d failures", report_count, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
